// File: design/aprc_pkg.sv
// Shared types and constants of the averaged proportional controller.
package aprc_pkg;

    localparam int CODE_W    = 12;
    localparam int DRIVE_W   = 8;
    localparam int ERR_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DEN_W     = 13;
    localparam int DRV_NUM_W = 21;

    localparam int CODE_FULL  = 4095;
    localparam int DRIVE_FULL = 255;
    localparam int DRV_MUL    = 510;
    localparam int DRV_DIV    = 8190;
    localparam int REF_RESET  = 3723;

    // Division by 8190 as a multiply by ceil(2^34 / 8190) and a shift by 34.
    // It is exact for every numerator below 2^21.
    localparam int DRV_RECIP   = 2097665;
    localparam int DRV_RECIP_W = 22;
    localparam int DRV_SHIFT   = 34;
    localparam int DRV_PROD_W  = DRV_NUM_W + DRV_RECIP_W;
    localparam int DRV_QUO_W   = DRV_PROD_W - DRV_SHIFT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF    = 2'd0,
        REG_BIAS   = 2'd1,
        REG_ENABLE = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_CTRL,
        ST_DRV_GO,
        ST_DRV_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: design/averaged_proportional_controller.sv
// Top level of the averaged proportional controller.
//
// The s_ channel takes one 12-bit converter sample per request (s_tdata[11:0]).
// Each sample enters a ring of WINDOW entries with a running sum; the average
// is the sum over the samples held so far, rounded half up. When loop_enable
// is set, error = ref_level - average and drive = bias_level + error, clamped
// to 0..4095, is scaled to an 8-bit code that is held; otherwise the held code
// is shown and error, saturated and updated read zero.
// The m_ channel returns one result per sample. The cfg_ channel writes the
// registers (index 0 ref_level, 1 bias_level, 2 loop_enable) in any cycle.
// Each sample passes through the read, divide, control and, with the loop
// enabled, drive states before the result register loads; a new sample is
// accepted in the cycle after it loads. The average comes from a divider that
// resolves one quotient bit per cycle over NUM_W bits (18 at the default
// window); the output scaling is a reciprocal multiply on a registered numerator.
// Reset restores the register defaults and empties the ring; no clearing pass
// runs. When the receiver stalls, a finished result waits in the output
// register while the next sample is already taken and worked on.
module averaged_proportional_controller #(
    parameter int WINDOW = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [11:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [11:0] average, [24:12] error_value, [32:25] drive_code, rest zero
    output logic [39:0]                    m_tdata,
    output logic [1:0]                     m_tuser,   // [0] saturated, [1] updated
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aprc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aprc_pkg::CODE_W-1:0]    cfg_data
);
    import aprc_pkg::*;

    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = $clog2(WINDOW * CODE_FULL + 1);
    localparam int AVG_NUM_W = SUM_W + 2;
    localparam int NUM_W     = AVG_NUM_W;

    ctrl_state_t state_reg, state_next;

    logic [CODE_W-1:0]        ref_reg;
    logic [CODE_W-1:0]        bias_reg;
    logic                     en_reg;

    logic [CODE_W-1:0]        sample_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     full_reg;
    logic [DRIVE_W-1:0]       held_reg;
    logic [CODE_W-1:0]        avg_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [CODE_W-1:0]        drive_reg;
    logic                     sat_reg;
    logic                     upd_reg;
    logic [DRV_NUM_W-1:0]     drv_num_reg;

    logic                     m_tvalid_reg;
    logic [CODE_W-1:0]        out_avg_reg;
    logic [ERR_W-1:0]         out_err_reg;
    logic [DRIVE_W-1:0]       out_drv_reg;
    logic                     out_sat_reg;
    logic                     out_upd_reg;

    logic                     ring_rd_en;
    logic                     ring_wr_en;
    logic [CODE_W-1:0]        ring_rd_data;
    logic                     div_start;
    logic                     out_load;
    div_status_t              div_st;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic [NUM_W-1:0]         div_quo;

    logic [CODE_W-1:0]        old_val;
    logic [SUM_W-1:0]         sum_upd;
    logic                     pos_last;
    logic [DEN_W-1:0]         den_cnt;
    logic [NUM_W-1:0]         avg_num;
    logic [DEN_W-1:0]         avg_den;
    logic [DRV_NUM_W-1:0]     drv_num;
    logic [DRV_PROD_W-1:0]    drv_prod;
    logic [DRV_QUO_W-1:0]     drv_quo;
    logic signed [ERR_W-1:0]  err_calc;
    logic signed [ERR_W:0]    drive_sum;
    logic [CODE_W-1:0]        drive_clamp;
    logic                     sat_calc;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg  <= CODE_W'(REF_RESET);
            bias_reg <= '0;
            en_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_REF) begin
                ref_reg <= cfg_data;
            end
            if (cfg_index == REG_BIAS) begin
                bias_reg <= cfg_data;
            end
            if (cfg_index == REG_ENABLE) begin
                en_reg <= cfg_data[0];
            end
        end
    end

    aprc_ring #(
        .DEPTH (WINDOW),
        .AW    (POS_W)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (ring_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ring_rd_data),
        .wr_en   (ring_wr_en),
        .wr_addr (pos_reg),
        .wr_data (sample_reg)
    );

    aprc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_quo),
        .status   (div_st)
    );

    // Running sum update: the oldest entry leaves only once the ring is full.
    assign old_val  = full_reg ? ring_rd_data : '0;
    assign sum_upd  = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);
    assign pos_last = (pos_reg == POS_W'(WINDOW - 1));

    // Round half up: (2*sum + n) / (2*n).
    assign den_cnt  = full_reg ? DEN_W'(WINDOW) : DEN_W'(pos_reg);
    assign avg_num  = NUM_W'({sum_reg, 1'b0}) + NUM_W'(den_cnt);
    assign avg_den  = {den_cnt[DEN_W-2:0], 1'b0};
    assign drv_num  = DRV_NUM_W'(drive_reg) * DRV_NUM_W'(DRV_MUL) + DRV_NUM_W'(CODE_FULL);
    assign drv_prod = DRV_PROD_W'(drv_num_reg) * DRV_PROD_W'(DRV_RECIP);
    assign drv_quo  = drv_prod[DRV_PROD_W-1:DRV_SHIFT];

    assign div_num  = avg_num;
    assign div_den  = avg_den;

    assign err_calc  = $signed({1'b0, ref_reg}) - $signed({1'b0, avg_reg});
    assign drive_sum = $signed({2'b00, bias_reg}) + $signed({err_calc[ERR_W-1], err_calc});

    always_comb begin
        sat_calc    = 1'b0;
        drive_clamp = drive_sum[CODE_W-1:0];
        if (drive_sum < 0) begin
            drive_clamp = '0;
            sat_calc    = 1'b1;
        end else if (drive_sum > $signed((ERR_W + 1)'(CODE_FULL))) begin
            drive_clamp = CODE_W'(CODE_FULL);
            sat_calc    = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:     state_next = ST_AVG_GO;
            ST_AVG_GO:   state_next = ST_AVG_WAIT;
            ST_AVG_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_CTRL;
                end
            end
            ST_CTRL:     state_next = en_reg ? ST_DRV_GO : ST_OUT;
            ST_DRV_GO:   state_next = ST_DRV_WAIT;
            ST_DRV_WAIT: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready   = 1'b0;
        ring_rd_en = 1'b0;
        ring_wr_en = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                ring_rd_en = s_tvalid;
            end
            ST_READ:   ring_wr_en = 1'b1;
            ST_AVG_GO: div_start  = 1'b1;
            ST_OUT:    out_load   = !m_tvalid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            full_reg <= 1'b0;
            held_reg <= '0;
        end else begin
            if (ring_wr_en) begin
                sum_reg <= sum_upd;
                if (pos_last) begin
                    pos_reg  <= '0;
                    full_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (state_reg == ST_DRV_WAIT) begin
                held_reg <= (drv_quo > DRV_QUO_W'(DRIVE_FULL)) ? DRIVE_W'(DRIVE_FULL)
                                                              : drv_quo[DRIVE_W-1:0];
            end
        end
    end

    // Per-item working values.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[CODE_W-1:0];
        end
        if (state_reg == ST_AVG_WAIT && div_st.done) begin
            avg_reg <= (div_quo > NUM_W'(CODE_FULL)) ? CODE_W'(CODE_FULL)
                                                     : div_quo[CODE_W-1:0];
        end
        if (state_reg == ST_CTRL) begin
            err_reg   <= en_reg ? err_calc : '0;
            sat_reg   <= en_reg ? sat_calc : 1'b0;
            upd_reg   <= en_reg;
            drive_reg <= drive_clamp;
        end
        if (state_reg == ST_DRV_GO) begin
            drv_num_reg <= drv_num;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_avg_reg <= avg_reg;
            out_err_reg <= err_reg;
            out_drv_reg <= held_reg;
            out_sat_reg <= sat_reg;
            out_upd_reg <= upd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_drv_reg, out_err_reg, out_avg_reg};
    assign m_tuser  = {out_upd_reg, out_sat_reg};

endmodule

// File: design/aprc_ring.sv
// Sample ring memory with one write port and one registered read port.
module aprc_ring #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [aprc_pkg::CODE_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [aprc_pkg::CODE_W-1:0] wr_data
);
    import aprc_pkg::*;

    logic [CODE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/aprc_div.sv
// Restoring divider that resolves one quotient bit per cycle.
module aprc_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic [NUM_W-1:0]      quotient,
    output aprc_pkg::div_status_t status
);
    import aprc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Shift the next numerator bit into the partial remainder and try the subtract.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: design/aprc_checker.sv
// Port-level checks of the averaged proportional controller and their binding.
module aprc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [15:0]                    s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [39:0]                    m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [aprc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [aprc_pkg::CODE_W-1:0]    cfg_data
);
    import aprc_pkg::*;

    // A stalled result must hold its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result is shown right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Samples are worked one at a time, so the input closes after a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while one is in work");

    // A result without a new drive carries no error and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> !m_tuser[0] && (m_tdata[24:12] == 13'd0))
        else $error("error or saturation shown while loop disabled");

endmodule

bind averaged_proportional_controller aprc_checker u_aprc_checker (.*);
